// File: design/red_dctcp_queue_marker_top_assert.svh
// Assertion macros for the queue marker block.
// Used by the top level; depends on nothing else.
`ifndef RED_DCTCP_QUEUE_MARKER_TOP_ASSERT_SVH
`define RED_DCTCP_QUEUE_MARKER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RDQM_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("queue marker assertion failed");
`define RDQM_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("queue marker assertion failed");
`else
`define RDQM_ASSERT(label, clk, rst, prop)
`define RDQM_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// File: design/rdqm_pkg.sv
// Shared types, codes and widths of the queue marker block.
// Used by every module of the block; depends on nothing.
`default_nettype none
package rdqm_pkg;

  localparam int NUM_QUEUES_DEF = 8;
  localparam int MAX_DEPTH      = 4096;

  localparam int CNT_W      = 13;
  localparam int AVG_W      = 32;
  localparam int LEN_W      = 13;
  localparam int QLEN_W     = 16;
  localparam int PROB_W     = 32;
  localparam int AVG_FRAC   = 16;
  localparam int AVG_DECAY  = 10;
  localparam int CNT_SCALE  = AVG_FRAC - AVG_DECAY;
  localparam int DIVIDEND_W = QLEN_W + PROB_W;
  localparam int DIVISOR_W  = LEN_W;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 72;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 32;

  localparam logic [1:0] OP_ARRIVE = 2'd0;
  localparam logic [1:0] OP_DEPART = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [1:0] VD_ACCEPT    = 2'd0;
  localparam logic [1:0] VD_RAND_DROP = 2'd1;
  localparam logic [1:0] VD_TAIL_DROP = 2'd2;
  localparam logic [1:0] VD_DISC_DROP = 2'd3;

  localparam logic [1:0] MODE_TAILDROP = 2'd0;
  localparam logic [1:0] MODE_RED      = 2'd1;
  localparam logic [1:0] MODE_DCTCP    = 2'd2;

  localparam logic [1:0] ECN_NOT_ECT = 2'd0;
  localparam logic [1:0] ECN_CE      = 2'd3;

  localparam int FLAG_GENTLE = 0;
  localparam int FLAG_ECN    = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_DISC_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_MIN_LEN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_MAX_LEN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_MAX_PROB   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_FLAGS      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MARK_THRESHOLD = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RAND_DROP_PROB = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_CAPACITY = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_DIVSTART,
    ST_DIVWAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [AVG_W-1:0] average;
  } entry_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// File: design/rdqm_state_mem.sv
// Per-queue state memory: count and moving average, one read port, one write port.
// Entries never written read as zero through reset-cleared valid bits; uses rdqm_pkg.
`default_nettype none
module rdqm_state_mem
  import rdqm_pkg::*;
#(
  parameter int NUM_QUEUES = NUM_QUEUES_DEF,
  parameter int ADDR_W     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output entry_t                 rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire entry_t            wr_data
);

  entry_t                mem [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] written;
  entry_t                rd_raw;
  logic                  rd_written;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw     <= mem[rd_addr];
      rd_written <= written[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_written ? rd_raw : '0;

endmodule
`default_nettype wire

// File: design/rdqm_divider.sv
// Bit-serial restoring divider for the RED probability, one quotient bit per cycle.
// The divisor is never zero when started; uses rdqm_pkg.
`default_nettype none
module rdqm_divider
  import rdqm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int STEP_W = $clog2(DIVIDEND_W);

  logic                  busy;
  logic                  done;
  logic [STEP_W-1:0]     step;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  den;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W:0]    rem_shift;
  logic [DIVISOR_W:0]    rem_diff;
  logic                  fits;

  assign rem_shift = {rem, quo[DIVIDEND_W-1]};
  assign rem_diff  = rem_shift - {1'b0, den};
  assign fits      = rem_shift >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && step == STEP_W'(DIVIDEND_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      step <= '0;
      rem  <= '0;
      den  <= req.divisor;
      quo  <= req.dividend;
    end else if (busy) begin
      step <= step + STEP_W'(1);
      rem  <= fits ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
      quo  <= {quo[DIVIDEND_W-2:0], fits};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule
`default_nettype wire

// File: design/red_dctcp_queue_marker_top.sv
// Each item passes IDLE (input transfer), READ, EVAL and FINISH, which loads the output
// register; a RED probability that needs the divide adds DIVSTART and DIVWAIT (48
// quotient bits, one per cycle, in the serial divider). One item at a time: the next
// is taken once FINISH loads the result, even while it waits in the output register.
// Reset (synchronous, rst high): registers take their reset values, all queues read
// as empty with zero average at once, and no clearing pass is needed.
`default_nettype none
module red_dctcp_queue_marker_top
  import rdqm_pkg::*;
#(
  parameter int NUM_QUEUES = NUM_QUEUES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // queue_sel[2:0], ecn_in[4:3], rand_drop_word[36:5], rand_red_word[68:37], zero fill
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  // op[1:0]
  input  wire logic [IN_TUSER_W-1:0]  s_tuser,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // verdict[1:0], ecn_out[3:2], occupancy[16:4], avg_len[29:17], zero fill
  output logic [OUT_TDATA_W-1:0]      m_tdata
);

  `include "red_dctcp_queue_marker_top_assert.svh"

  localparam int         ADDR_W    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam logic [8:0] SEL_LIMIT = 9'(NUM_QUEUES);
  localparam logic [16:0] DEPTH_LIMIT = 17'(MAX_DEPTH);

  logic [1:0]        disc_mode;
  logic [LEN_W-1:0]  red_min_len;
  logic [LEN_W-1:0]  red_max_len;
  logic [PROB_W-1:0] red_max_prob;
  logic [1:0]        red_flags;
  logic [LEN_W-1:0]  mark_threshold;
  logic [PROB_W-1:0] rand_drop_prob;
  logic [LEN_W-1:0]  queue_capacity;

  state_t state;
  state_t state_next;

  logic [1:0]        op_r;
  logic [2:0]        sel_r;
  logic [1:0]        ecn_r;
  logic [31:0]       rdrop_r;
  logic [31:0]       rred_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [AVG_W-1:0]  avg_r;
  logic [DIVIDEND_W-1:0] prod_r;
  logic [DIVISOR_W-1:0]  den_r;
  logic              gentle_r;
  logic              need_red_r;
  logic [PROB_W-1:0] prob_r;

  entry_t   rd_data;
  entry_t   wr_data;
  logic     rd_en;
  logic     wr_en;
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     out_free;
  logic     out_load;

  logic              q_valid;
  logic              rand_hit;
  logic [LEN_W-1:0]  cap;
  logic [QLEN_W-1:0] qlen;
  logic              capable;
  logic              use_ecn;
  logic              full;
  logic              red_need;
  logic              below_max;
  logic [LEN_W-1:0]  span;
  logic              need_div;
  logic              div_gentle;
  logic [QLEN_W-1:0] mul_a;
  logic [PROB_W-1:0] mul_b;
  logic [DIVISOR_W-1:0] div_den;
  logic [PROB_W-1:0] prob_imm;
  logic [PROB_W-1:0] prob_div;
  logic [PROB_W-1:0] inv_max_prob;

  logic [1:0]       verdict_f;
  logic [1:0]       ecn_f;
  logic [CNT_W-1:0] cnt_f;
  logic [AVG_W-1:0] avg_f;
  logic             red_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      disc_mode      <= MODE_TAILDROP;
      red_min_len    <= LEN_W'(50);
      red_max_len    <= LEN_W'(150);
      red_max_prob   <= PROB_W'(429496729);
      red_flags      <= 2'd0;
      mark_threshold <= LEN_W'(64);
      rand_drop_prob <= '0;
      queue_capacity <= LEN_W'(4096);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DISC_MODE:      disc_mode      <= cfg_data[1:0];
        CFG_RED_MIN_LEN:    red_min_len    <= cfg_data[LEN_W-1:0];
        CFG_RED_MAX_LEN:    red_max_len    <= cfg_data[LEN_W-1:0];
        CFG_RED_MAX_PROB:   red_max_prob   <= cfg_data[PROB_W-1:0];
        CFG_RED_FLAGS:      red_flags      <= cfg_data[1:0];
        CFG_MARK_THRESHOLD: mark_threshold <= cfg_data[LEN_W-1:0];
        CFG_RAND_DROP_PROB: rand_drop_prob <= cfg_data[PROB_W-1:0];
        CFG_QUEUE_CAPACITY: queue_capacity <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  rdqm_state_mem #(
    .NUM_QUEUES (NUM_QUEUES),
    .ADDR_W     (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (ADDR_W'(s_tdata[2:0])),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (ADDR_W'(sel_r)),
    .wr_data (wr_data)
  );

  rdqm_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Decision terms shared by the evaluate and finish steps.
  assign q_valid  = {6'd0, sel_r} < SEL_LIMIT;
  assign rand_hit = (rand_drop_prob != '0) && (rdrop_r <= rand_drop_prob);
  assign cap      = ({4'd0, queue_capacity} < DEPTH_LIMIT) ? queue_capacity
                                                           : LEN_W'(MAX_DEPTH);
  assign qlen     = avg_r[AVG_W-1:AVG_FRAC];
  assign capable  = (ecn_r != ECN_NOT_ECT) && (ecn_r != ECN_CE);
  assign use_ecn  = red_flags[FLAG_ECN];
  assign full     = cnt_r >= cap;
  assign red_need = (op_r == OP_ARRIVE) && !rand_hit && q_valid && !full &&
                    (disc_mode == MODE_RED) && (!use_ecn || capable) &&
                    (qlen >= {3'd0, red_min_len});
  assign below_max    = qlen <= {3'd0, red_max_len};
  assign span         = red_max_len - red_min_len;
  assign inv_max_prob = ~red_max_prob;

  always_comb begin
    need_div   = 1'b0;
    div_gentle = 1'b0;
    mul_a      = {3'd0, qlen[LEN_W-1:0] - red_min_len};
    mul_b      = red_max_prob;
    div_den    = span;
    prob_imm   = red_max_prob;
    if (below_max) begin
      if (span == '0) begin
        prob_imm = '0;
      end else begin
        need_div = red_need;
      end
    end else if (red_flags[FLAG_GENTLE]) begin
      mul_a   = qlen - {3'd0, red_max_len};
      mul_b   = inv_max_prob;
      div_den = cap - red_max_len;
      if (cap <= red_max_len) begin
        prob_imm = '1;
      end else begin
        need_div   = red_need;
        div_gentle = 1'b1;
      end
    end
  end

  always_comb begin
    if (gentle_r) begin
      if (div_rsp.quotient > {16'd0, inv_max_prob}) begin
        prob_div = '1;
      end else begin
        prob_div = red_max_prob + div_rsp.quotient[PROB_W-1:0];
      end
    end else begin
      prob_div = div_rsp.quotient[PROB_W-1:0];
    end
  end

  assign red_hit = rred_r <= prob_r;

  always_comb begin
    verdict_f = VD_ACCEPT;
    ecn_f     = 2'd0;
    cnt_f     = cnt_r;
    avg_f     = avg_r;
    case (op_r)
      OP_ARRIVE: begin
        ecn_f = ecn_r;
        if (rand_hit) begin
          verdict_f = VD_RAND_DROP;
        end else if (!q_valid || full) begin
          verdict_f = VD_TAIL_DROP;
        end else begin
          if (need_red_r && red_hit) begin
            if (use_ecn) begin
              ecn_f = ECN_CE;
            end else begin
              verdict_f = VD_DISC_DROP;
            end
          end
          if ((disc_mode == MODE_DCTCP) && capable && (qlen >= {3'd0, mark_threshold})) begin
            ecn_f = ECN_CE;
          end
          if (verdict_f == VD_ACCEPT) begin
            cnt_f = cnt_r + CNT_W'(1);
          end
        end
      end
      OP_DEPART: begin
        if (cnt_r != '0) begin
          cnt_f = cnt_r - CNT_W'(1);
        end
      end
      OP_TICK: begin
        avg_f = avg_r + {13'd0, cnt_r, {CNT_SCALE{1'b0}}}
                      - {{AVG_DECAY{1'b0}}, avg_r[AVG_W-1:AVG_DECAY]};
      end
      default: ;
    endcase
  end

  assign wr_data.count   = cnt_f;
  assign wr_data.average = avg_f;
  assign out_free        = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (s_tvalid) state_next = ST_READ;
      ST_READ:     state_next = ST_EVAL;
      ST_EVAL:     state_next = need_div ? ST_DIVSTART : ST_FINISH;
      ST_DIVSTART: state_next = ST_DIVWAIT;
      ST_DIVWAIT:  if (div_rsp.done) state_next = ST_FINISH;
      ST_FINISH:   if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready         = 1'b0;
    rd_en            = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = prod_r;
    div_req.divisor  = den_r;
    out_load         = 1'b0;
    wr_en            = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        rd_en    = s_tvalid;
      end
      ST_DIVSTART: div_req.start = 1'b1;
      ST_FINISH: begin
        out_load = out_free;
        wr_en    = out_free && q_valid;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_r    <= s_tuser[1:0];
      sel_r   <= s_tdata[2:0];
      ecn_r   <= s_tdata[4:3];
      rdrop_r <= s_tdata[36:5];
      rred_r  <= s_tdata[68:37];
    end
    if (state == ST_READ) begin
      cnt_r <= rd_data.count;
      avg_r <= rd_data.average;
    end
    if (state == ST_EVAL) begin
      prod_r     <= mul_a * mul_b;
      den_r      <= div_den;
      gentle_r   <= div_gentle;
      need_red_r <= red_need;
      prob_r     <= prob_imm;
    end
    if (state == ST_DIVWAIT && div_rsp.done) begin
      prob_r <= prob_div;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {2'd0,
                  q_valid ? avg_f[AVG_FRAC+LEN_W-1:AVG_FRAC] : {LEN_W{1'b0}},
                  q_valid ? cnt_f : {CNT_W{1'b0}},
                  ecn_f,
                  verdict_f};
    end
  end

  `RDQM_ASSERT(a_busy_after_accept, clk, rst, s_tvalid && s_tready |=> !s_tready)
  `RDQM_ASSERT(a_div_start_idle, clk, rst, div_req.start |-> !div_rsp.busy)
  `RDQM_ASSERT(a_div_done_waited, clk, rst, div_rsp.done |-> state == ST_DIVWAIT)
  `RDQM_ASSERT(a_result_shown, clk, rst, out_load |=> m_tvalid)

endmodule
`default_nettype wire
